### sv/midi_byte_stream_parser_assert.svh
// Assertion macros shared by the MIDI byte stream parser RTL.
// Depends on nothing; included by the top level.
`ifndef MIDI_BYTE_STREAM_PARSER_ASSERT_SVH
`define MIDI_BYTE_STREAM_PARSER_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define MBSP_ASSERT_ALWAYS(name, clk, rst, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Implication checked in the same cycle.
`define MBSP_ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

### sv/mbsp_pkg.sv
// Package of the MIDI byte stream parser: status constants, event codes,
// byte classes and the structs passed between the front, queue and back.
`timescale 1ns / 1ps

package mbsp_pkg;

  // Status byte values.
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_MTC       = 8'hF1;
  localparam logic [7:0] ST_SONGPOS   = 8'hF2;
  localparam logic [7:0] ST_SONGSEL   = 8'hF3;
  localparam logic [7:0] ST_TUNE      = 8'hF6;
  localparam logic [7:0] ST_EOX       = 8'hF7;
  localparam logic [7:0] ST_REALTIME  = 8'hF8;
  localparam logic [3:0] HI_PROG      = 4'hC;
  localparam logic [3:0] HI_CHAN_AT   = 4'hD;

  // Event codes on event_res.
  localparam logic [4:0] EV_MTC       = 5'd7;
  localparam logic [4:0] EV_SONGPOS   = 5'd8;
  localparam logic [4:0] EV_SONGSEL   = 5'd9;
  localparam logic [4:0] EV_TUNE      = 5'd10;
  localparam logic [4:0] EV_SYSEX     = 5'd11;
  localparam logic [4:0] EV_CLOCK     = 5'd12;
  localparam logic [4:0] EV_TICK      = 5'd13;
  localparam logic [4:0] EV_START     = 5'd14;
  localparam logic [4:0] EV_CONTINUE  = 5'd15;
  localparam logic [4:0] EV_STOP      = 5'd16;
  localparam logic [4:0] EV_SENSING   = 5'd17;
  localparam logic [4:0] EV_RESET     = 5'd18;
  localparam logic [4:0] EV_UNKNOWN   = 5'd19;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    CLS_REALTIME    = 4'd0,  // F8..FF
    CLS_SYSEX_START = 4'd1,  // F0
    CLS_EOX         = 4'd2,  // F7
    CLS_COMMON1     = 4'd3,  // F1, F3
    CLS_COMMON2     = 4'd4,  // F2
    CLS_TUNE        = 4'd5,  // F6
    CLS_UNDEF       = 4'd6,  // F4, F5
    CLS_CHAN_STATUS = 4'd7,  // 80..EF
    CLS_DATA        = 4'd8   // 00..7F
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [7:0] rx;
    logic [4:0] rt_event;
  } item_t;

  typedef struct packed {
    logic [4:0] event_res;
    logic [7:0] status_byte;
    logic [7:0] first_data;
    logic [7:0] second_data;
    logic [3:0] midi_channel;
    logic [8:0] msg_length;
    logic       last_of_run;
    logic       sysex_overflow;
  } result_t;

endpackage

### sv/mbsp_in_if.sv
// Input channel of the MIDI byte stream parser: one received byte per
// transaction. Depends on nothing.
`timescale 1ns / 1ps

interface mbsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

### sv/mbsp_out_if.sv
// Output channel of the MIDI byte stream parser: one decoded item per
// transaction. Depends on nothing.
`timescale 1ns / 1ps

interface mbsp_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] event_res;
  logic [7:0] status_byte;
  logic [7:0] first_data;
  logic [7:0] second_data;
  logic [3:0] midi_channel;
  logic [8:0] msg_length;
  logic       last_of_run;
  logic       sysex_overflow;

  modport source (output valid, output event_res, output status_byte, output first_data,
                  output second_data, output midi_channel, output msg_length,
                  output last_of_run, output sysex_overflow, input ready);
  modport sink (input valid, input event_res, input status_byte, input first_data,
                input second_data, input midi_channel, input msg_length,
                input last_of_run, input sysex_overflow, output ready);
endinterface

### sv/mbsp_front.sv
// Front end: classifies each received byte and hands it to the queue.
// Depends on mbsp_pkg and mbsp_in_if.
`timescale 1ns / 1ps

module mbsp_front (
  mbsp_in_if.sink       in_ch,
  input  logic          q_ready,
  output logic          q_push,
  output mbsp_pkg::item_t q_item
);

  logic [7:0] b;

  assign b           = in_ch.rx_byte;
  assign in_ch.ready = q_ready;
  assign q_push      = in_ch.valid && q_ready;

  always_comb begin
    q_item          = '0;
    q_item.rx       = b;
    q_item.cls      = mbsp_pkg::CLS_DATA;
    q_item.rt_event = mbsp_pkg::EV_UNKNOWN;
    if (b >= mbsp_pkg::ST_REALTIME) begin
      q_item.cls = mbsp_pkg::CLS_REALTIME;
      unique case (b[2:0])
        3'd0:    q_item.rt_event = mbsp_pkg::EV_CLOCK;
        3'd1:    q_item.rt_event = mbsp_pkg::EV_TICK;
        3'd2:    q_item.rt_event = mbsp_pkg::EV_START;
        3'd3:    q_item.rt_event = mbsp_pkg::EV_CONTINUE;
        3'd4:    q_item.rt_event = mbsp_pkg::EV_STOP;
        3'd6:    q_item.rt_event = mbsp_pkg::EV_SENSING;
        3'd7:    q_item.rt_event = mbsp_pkg::EV_RESET;
        default: q_item.rt_event = mbsp_pkg::EV_UNKNOWN;
      endcase
    end else if (b[7:4] == 4'hF) begin
      unique case (b[2:0]) inside
        3'd0:      q_item.cls = mbsp_pkg::CLS_SYSEX_START;
        3'd1, 3'd3: q_item.cls = mbsp_pkg::CLS_COMMON1;
        3'd2:      q_item.cls = mbsp_pkg::CLS_COMMON2;
        3'd6:      q_item.cls = mbsp_pkg::CLS_TUNE;
        3'd7:      q_item.cls = mbsp_pkg::CLS_EOX;
        default:   q_item.cls = mbsp_pkg::CLS_UNDEF;
      endcase
    end else if (b[7]) begin
      q_item.cls = mbsp_pkg::CLS_CHAN_STATUS;
    end
  end

endmodule

### sv/mbsp_queue.sv
// Short queue of classified bytes between the front and the back end.
// Depends on mbsp_pkg.
`timescale 1ns / 1ps

module mbsp_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  mbsp_pkg::item_t               push_item,
  output logic                          push_ready,
  input  logic                          pop,
  output logic                          pop_valid,
  output mbsp_pkg::item_t               pop_item,
  output logic [mbsp_pkg::QLVL_W-1:0]   level
);

  mbsp_pkg::item_t                slots [mbsp_pkg::QUEUE_DEPTH];
  logic [mbsp_pkg::QPTR_W-1:0]    wr_ptr;
  logic [mbsp_pkg::QPTR_W-1:0]    rd_ptr;

  assign push_ready = level != mbsp_pkg::QLVL_W'(mbsp_pkg::QUEUE_DEPTH);
  assign pop_valid  = level != '0;
  assign pop_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

### sv/mbsp_back.sv
// Back end: keeps the running status, system common and SysEx state and
// builds the decoded items in an output register. Depends on mbsp_pkg, mbsp_out_if.
`timescale 1ns / 1ps

module mbsp_back #(
  parameter int SYSEX_CAPACITY = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  mbsp_pkg::item_t q_item,
  output logic            q_pop,
  mbsp_out_if.source      out_ch
);

  localparam int CW = $clog2(SYSEX_CAPACITY + 1);

  logic [7:0]    run_status, run_status_next;
  logic [1:0]    chan_expected, chan_expected_next;
  logic          chan_count, chan_count_next;
  logic [7:0]    chan_first_byte, chan_first_byte_next;
  logic [7:0]    common_status, common_status_next;
  logic [1:0]    common_expected, common_expected_next;
  logic          common_count, common_count_next;
  logic [7:0]    common_first_byte, common_first_byte_next;
  logic          sysex_active, sysex_active_next;
  logic [CW-1:0] sysex_count, sysex_count_next;
  logic          sysex_dropped, sysex_dropped_next;

  logic              emit;
  mbsp_pkg::result_t res;
  mbsp_pkg::result_t out_res;
  logic              out_valid;
  logic [7:0]        b;
  logic              kept;

  assign b     = q_item.rx;
  assign q_pop = q_valid && (!out_valid || out_ch.ready);

  always_comb begin
    run_status_next        = run_status;
    chan_expected_next     = chan_expected;
    chan_count_next        = chan_count;
    chan_first_byte_next   = chan_first_byte;
    common_status_next     = common_status;
    common_expected_next   = common_expected;
    common_count_next      = common_count;
    common_first_byte_next = common_first_byte;
    sysex_active_next      = sysex_active;
    sysex_count_next       = sysex_count;
    sysex_dropped_next     = sysex_dropped;
    emit                   = 1'b0;
    res                    = '0;
    kept                   = 1'b0;

    if (q_item.cls == mbsp_pkg::CLS_REALTIME) begin
      // Realtime leaves all message state untouched.
      emit            = 1'b1;
      res.event_res   = q_item.rt_event;
      res.status_byte = b;
      res.msg_length  = 9'd1;
      res.last_of_run = 1'b1;
    end else if (q_item.cls == mbsp_pkg::CLS_SYSEX_START) begin
      // A new SysEx abandons any open one.
      common_status_next = '0;
      common_count_next  = 1'b0;
      sysex_active_next  = 1'b1;
      sysex_dropped_next = 1'b0;
      sysex_count_next   = CW'(1);
      emit               = 1'b1;
      res.event_res      = mbsp_pkg::EV_SYSEX;
      res.status_byte    = mbsp_pkg::ST_SYSEX;
      res.first_data     = b;
      res.msg_length     = 9'd1;
    end else if (sysex_active) begin
      kept = sysex_count < CW'(SYSEX_CAPACITY);
      if (kept) begin
        sysex_count_next = sysex_count + 1'b1;
      end else begin
        sysex_dropped_next = 1'b1;
      end
      res.event_res   = mbsp_pkg::EV_SYSEX;
      res.status_byte = mbsp_pkg::ST_SYSEX;
      res.first_data  = b;
      res.msg_length  = 9'(sysex_count_next);
      if (q_item.cls == mbsp_pkg::CLS_EOX) begin
        sysex_active_next  = 1'b0;
        emit               = 1'b1;
        res.last_of_run    = 1'b1;
        res.sysex_overflow = sysex_dropped_next;
      end else begin
        emit = kept;
      end
    end else begin
      unique case (q_item.cls) inside
        mbsp_pkg::CLS_COMMON1, mbsp_pkg::CLS_COMMON2, mbsp_pkg::CLS_TUNE,
        mbsp_pkg::CLS_UNDEF, mbsp_pkg::CLS_EOX: begin
          common_status_next   = '0;
          common_count_next    = 1'b0;
          common_expected_next = 2'd0;
          if (q_item.cls == mbsp_pkg::CLS_COMMON1) begin
            common_status_next   = b;
            common_expected_next = 2'd1;
          end else if (q_item.cls == mbsp_pkg::CLS_COMMON2) begin
            common_status_next   = b;
            common_expected_next = 2'd2;
          end else begin
            emit            = 1'b1;
            res.event_res   = (q_item.cls == mbsp_pkg::CLS_TUNE) ? mbsp_pkg::EV_TUNE
                                                                 : mbsp_pkg::EV_UNKNOWN;
            res.status_byte = b;
            res.msg_length  = 9'd1;
            res.last_of_run = 1'b1;
          end
        end
        mbsp_pkg::CLS_CHAN_STATUS: begin
          common_status_next = '0;
          common_count_next  = 1'b0;
          run_status_next    = b;
          chan_count_next    = 1'b0;
          chan_expected_next = (b[7:4] == mbsp_pkg::HI_PROG ||
                                b[7:4] == mbsp_pkg::HI_CHAN_AT) ? 2'd1 : 2'd2;
        end
        mbsp_pkg::CLS_DATA: begin
          if (common_status != '0) begin
            if (!common_count && common_expected == 2'd2) begin
              common_first_byte_next = b;
              common_count_next      = 1'b1;
            end else begin
              common_status_next = '0;
              common_count_next  = 1'b0;
              emit               = 1'b1;
              res.status_byte    = common_status;
              res.last_of_run    = 1'b1;
              if (common_status == mbsp_pkg::ST_MTC) begin
                res.event_res = mbsp_pkg::EV_MTC;
              end else if (common_status == mbsp_pkg::ST_SONGPOS) begin
                res.event_res = mbsp_pkg::EV_SONGPOS;
              end else begin
                res.event_res = mbsp_pkg::EV_SONGSEL;
              end
              if (common_expected == 2'd2) begin
                res.first_data  = common_first_byte;
                res.second_data = b;
                res.msg_length  = 9'd3;
              end else begin
                res.first_data = b;
                res.msg_length = 9'd2;
              end
            end
          end else if (run_status != '0) begin
            if (chan_expected == 2'd2 && !chan_count) begin
              chan_first_byte_next = b;
              chan_count_next      = 1'b1;
            end else begin
              chan_count_next  = 1'b0;
              emit             = 1'b1;
              res.event_res    = {2'b00, run_status[6:4]};
              res.status_byte  = run_status;
              res.midi_channel = run_status[3:0];
              res.last_of_run  = 1'b1;
              if (chan_expected == 2'd2) begin
                res.first_data  = chan_first_byte;
                res.second_data = b;
                res.msg_length  = 9'd3;
              end else begin
                res.first_data = b;
                res.msg_length = 9'd2;
              end
            end
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_status        <= '0;
      chan_expected     <= '0;
      chan_count        <= 1'b0;
      chan_first_byte   <= '0;
      common_status     <= '0;
      common_expected   <= '0;
      common_count      <= 1'b0;
      common_first_byte <= '0;
      sysex_active      <= 1'b0;
      sysex_count       <= '0;
      sysex_dropped     <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (q_pop) begin
        run_status        <= run_status_next;
        chan_expected     <= chan_expected_next;
        chan_count        <= chan_count_next;
        chan_first_byte   <= chan_first_byte_next;
        common_status     <= common_status_next;
        common_expected   <= common_expected_next;
        common_count      <= common_count_next;
        common_first_byte <= common_first_byte_next;
        sysex_active      <= sysex_active_next;
        sysex_count       <= sysex_count_next;
        sysex_dropped     <= sysex_dropped_next;
        out_valid         <= emit;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      out_res <= res;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.event_res      = out_res.event_res;
  assign out_ch.status_byte    = out_res.status_byte;
  assign out_ch.first_data     = out_res.first_data;
  assign out_ch.second_data    = out_res.second_data;
  assign out_ch.midi_channel   = out_res.midi_channel;
  assign out_ch.msg_length     = out_res.msg_length;
  assign out_ch.last_of_run    = out_res.last_of_run;
  assign out_ch.sysex_overflow = out_res.sysex_overflow;

endmodule

### sv/midi_byte_stream_parser.sv
// Top level of the MIDI byte stream parser: front classifier, queue, back end.
// Depends on mbsp_pkg, mbsp_in_if, mbsp_out_if, mbsp_front, mbsp_queue, mbsp_back
// and the assertion macro header.
`timescale 1ns / 1ps

// The parser takes one received MIDI byte per transaction on in_ch and gives at
// most one decoded item per byte on out_ch. It sustains one byte per clock
// cycle while out_ch does not stall: the front classifies a byte in the cycle
// it is accepted and writes it into a two-entry queue, and the back end reads
// one queued byte per cycle while the output register is empty or being taken,
// updates the running status, system common and SysEx state and loads the
// result into the output register. A byte passes the queue and the output
// register before its result is shown on out_ch. The queue lets the receiver
// keep sending while a finished result waits on out_ch: with out_ch stalled,
// in_ch fills the queue and then drops ready until the result is taken.
// The back end keeps draining whenever the output register is empty or being
// taken. Realtime bytes are reported immediately without disturbing a pending
// message. Channel messages follow running status; system common messages F1,
// F2 and F3 collect their data bytes; SysEx is streamed one item per kept
// byte, with the F7 item marked last and flagging overflow when bytes past
// SYSEX_CAPACITY were dropped. Bytes that complete nothing give no item.
module midi_byte_stream_parser #(
  parameter int SYSEX_CAPACITY = 256
) (
  input  logic        clk,
  input  logic        rst,
  mbsp_in_if.sink     in_ch,
  mbsp_out_if.source  out_ch
);

`include "midi_byte_stream_parser_assert.svh"

  logic                              q_push;
  logic                              q_ready;
  mbsp_pkg::item_t                   q_in_item;
  logic                              q_pop;
  logic                              q_valid;
  mbsp_pkg::item_t                   q_out_item;
  logic [mbsp_pkg::QLVL_W-1:0]       q_level;

  // Classification of each accepted byte.
  mbsp_front u_front (
    .in_ch   (in_ch),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_item  (q_in_item)
  );

  // Decouples the receiver side from the result side.
  mbsp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_in_item),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_item   (q_out_item),
    .level      (q_level)
  );

  // Message state and the output register.
  mbsp_back #(
    .SYSEX_CAPACITY (SYSEX_CAPACITY)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_out_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  // The queue never holds more entries than it has slots.
  `MBSP_ASSERT_ALWAYS(a_queue_bound, clk, rst,
                      q_level <= mbsp_pkg::QLVL_W'(mbsp_pkg::QUEUE_DEPTH),
                      "queue level exceeds its depth")

  // Only SysEx items may leave a message open.
  `MBSP_ASSERT_IMPLIES(a_open_is_sysex, clk, rst,
                       out_ch.valid && !out_ch.last_of_run,
                       out_ch.event_res == mbsp_pkg::EV_SYSEX,
                       "non-final item that is not SysEx")

  // Overflow is flagged only on the closing SysEx item.
  `MBSP_ASSERT_IMPLIES(a_overflow_at_end, clk, rst,
                       out_ch.valid && out_ch.sysex_overflow,
                       out_ch.last_of_run && out_ch.event_res == mbsp_pkg::EV_SYSEX,
                       "overflow flag outside SysEx end")

  // A nonzero channel only comes with a channel voice event.
  `MBSP_ASSERT_IMPLIES(a_channel_voice, clk, rst,
                       out_ch.valid && out_ch.midi_channel != 4'd0,
                       out_ch.event_res < mbsp_pkg::EV_MTC,
                       "channel set on a non-channel event")

endmodule
